/* rtl/ultrasonic_range_controller_defines.svh */
// ---------------------------------------------------------------------------
// Ultrasonic range controller assertion macros
// Clocked property checks; they compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_CONTROLLER_DEFINES_SVH
`define ULTRASONIC_RANGE_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
`define URC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("urc assertion failed");
`define URC_NEVER(label, cond) `URC_ASSERT(label, !(cond))
`else
`define URC_ASSERT(label, prop)
`define URC_NEVER(label, cond)
`endif

`endif

/* rtl/urc_pkg.sv */
// ---------------------------------------------------------------------------
// Ultrasonic range controller package
// Shared widths, phase and register codes, config and result beat types.
// ---------------------------------------------------------------------------
package urc_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int TIMER_BITS    = 20;
    localparam int DIST_BITS     = 14;
    localparam int THRESH_BITS   = 10;
    localparam int HOLDOFF_BITS  = 20;
    localparam int PULSE_BITS    = 8;
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    // ticks*17 fits in COUNT_BITS+5 bits; divide by 100 through a reciprocal
    localparam int PROD_BITS   = COUNT_BITS + 5;
    localparam int RECIP_SHIFT = PROD_BITS + 7;
    localparam int RECIP_BITS  = RECIP_SHIFT - 6;
    localparam int QUO_BITS    = PROD_BITS - 6;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'((64'd1 << RECIP_SHIFT) / 100 + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
    localparam logic [DIST_BITS-1:0]  DIST_MAX  = '1;

    localparam logic [1:0] IND_OFF  = 2'b00;
    localparam logic [1:0] IND_NEAR = 2'b01;
    localparam logic [1:0] IND_FAR  = 2'b10;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_HOLDOFF   = 2'd1;
    localparam logic [1:0] REG_TRIGGER   = 2'd2;
    localparam logic [1:0] REG_PRE_LOW   = 2'd3;

    typedef enum logic [2:0] {
        PH_PRE_LOW   = 3'd0,
        PH_TRIG_HIGH = 3'd1,
        PH_WAIT_ECHO = 3'd2,
        PH_COUNT     = 3'd3,
        PH_HOLDOFF   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0]  threshold_cm;
        logic [HOLDOFF_BITS-1:0] holdoff_ticks;
        logic [PULSE_BITS-1:0]   trigger_ticks;
        logic [PULSE_BITS-1:0]   pre_low_ticks;
    } cfg_t;

    typedef struct packed {
        logic                 trigger_level;
        logic                 distance_valid;
        logic [DIST_BITS-1:0] distance_cm;
        logic                 led_near;
        logic                 led_far;
    } result_t;

endpackage

/* rtl/urc_cfg_regs.sv */
// ---------------------------------------------------------------------------
// Ultrasonic range controller config registers
// APB register file for threshold, holdoff and pulse lengths.
// ---------------------------------------------------------------------------
module urc_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [urc_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [urc_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [urc_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    output urc_pkg::cfg_t                        cfg
);

    urc_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_cm  <= urc_pkg::THRESH_BITS'(10);
            cfg_reg.holdoff_ticks <= urc_pkg::HOLDOFF_BITS'(10000);
            cfg_reg.trigger_ticks <= urc_pkg::PULSE_BITS'(1);
            cfg_reg.pre_low_ticks <= urc_pkg::PULSE_BITS'(1);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                urc_pkg::REG_THRESHOLD:
                    cfg_reg.threshold_cm <= pwdata[urc_pkg::THRESH_BITS-1:0];
                urc_pkg::REG_HOLDOFF:
                    cfg_reg.holdoff_ticks <= pwdata[urc_pkg::HOLDOFF_BITS-1:0];
                urc_pkg::REG_TRIGGER:
                    cfg_reg.trigger_ticks <= pwdata[urc_pkg::PULSE_BITS-1:0];
                urc_pkg::REG_PRE_LOW:
                    cfg_reg.pre_low_ticks <= pwdata[urc_pkg::PULSE_BITS-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            urc_pkg::REG_THRESHOLD:
                prdata = urc_pkg::CFG_DATA_BITS'(cfg_reg.threshold_cm);
            urc_pkg::REG_HOLDOFF:
                prdata = urc_pkg::CFG_DATA_BITS'(cfg_reg.holdoff_ticks);
            urc_pkg::REG_TRIGGER:
                prdata = urc_pkg::CFG_DATA_BITS'(cfg_reg.trigger_ticks);
            urc_pkg::REG_PRE_LOW:
                prdata = urc_pkg::CFG_DATA_BITS'(cfg_reg.pre_low_ticks);
            default:
                prdata = '0;
        endcase
    end

endmodule

/* rtl/urc_core.sv */
// ---------------------------------------------------------------------------
// Ultrasonic range controller core
// Phase sequencer, phase timer, echo counter and distance conversion.
// ---------------------------------------------------------------------------
`include "ultrasonic_range_controller_defines.svh"

module urc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              echo_level,
    input  urc_pkg::cfg_t     cfg,
    output urc_pkg::result_t  result
);

    urc_pkg::phase_t                    phase_reg, phase_next;
    logic [urc_pkg::TIMER_BITS-1:0]     timer_reg, timer_next;
    logic [urc_pkg::COUNT_BITS-1:0]     echo_ticks_reg, echo_ticks_next;
    logic [urc_pkg::DIST_BITS-1:0]      dist_reg, dist_next;
    logic [1:0]                         indicator_reg, indicator_next;

    logic [urc_pkg::HOLDOFF_BITS-1:0]   lim;
    logic [urc_pkg::TIMER_BITS-1:0]     lim_clip;
    logic [urc_pkg::TIMER_BITS-1:0]     timer_inc;
    logic                               timer_done;
    logic [urc_pkg::PULSE_BITS-1:0]     trig_lim, pre_lim;
    logic [urc_pkg::PROD_BITS-1:0]      prod17;
    logic [urc_pkg::PROD_BITS+urc_pkg::RECIP_BITS-1:0] prod_recip;
    logic [urc_pkg::QUO_BITS-1:0]       quo;
    logic [urc_pkg::DIST_BITS-1:0]      dist_calc;
    logic                               trig;
    logic                               valid;

    // zero pulse lengths act as one tick
    assign trig_lim = (cfg.trigger_ticks == '0) ? urc_pkg::PULSE_BITS'(1) : cfg.trigger_ticks;
    assign pre_lim  = (cfg.pre_low_ticks == '0) ? urc_pkg::PULSE_BITS'(1) : cfg.pre_low_ticks;

    always_comb
    begin
        case (phase_reg)
            urc_pkg::PH_TRIG_HIGH: lim = urc_pkg::HOLDOFF_BITS'(trig_lim);
            urc_pkg::PH_HOLDOFF:   lim = cfg.holdoff_ticks;
            default:               lim = urc_pkg::HOLDOFF_BITS'(pre_lim);
        endcase
    end

    assign lim_clip = (32'(lim) > 32'(urc_pkg::TIMER_MAX)) ? urc_pkg::TIMER_MAX
                                                           : urc_pkg::TIMER_BITS'(lim);
    assign timer_inc  = (timer_reg < urc_pkg::TIMER_MAX) ? timer_reg + 1'b1 : timer_reg;
    assign timer_done = (timer_inc >= lim_clip);

    // floor(ticks*17/100): shift-add by 17, then reciprocal multiply
    assign prod17     = (urc_pkg::PROD_BITS'(echo_ticks_reg) << 4)
                      + urc_pkg::PROD_BITS'(echo_ticks_reg);
    assign prod_recip = (urc_pkg::PROD_BITS+urc_pkg::RECIP_BITS)'(prod17)
                      * (urc_pkg::PROD_BITS+urc_pkg::RECIP_BITS)'(urc_pkg::RECIP);
    assign quo        = prod_recip[urc_pkg::RECIP_SHIFT +: urc_pkg::QUO_BITS];
    assign dist_calc  = (32'(quo) > 32'(urc_pkg::DIST_MAX)) ? urc_pkg::DIST_MAX
                                                            : urc_pkg::DIST_BITS'(quo);

    always_comb
    begin
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        echo_ticks_next = echo_ticks_reg;
        dist_next       = dist_reg;
        indicator_next  = indicator_reg;
        trig            = 1'b0;
        valid           = 1'b0;
        unique case (phase_reg)
            urc_pkg::PH_TRIG_HIGH:
            begin
                trig       = 1'b1;
                timer_next = timer_inc;
                if (timer_done)
                begin
                    phase_next = urc_pkg::PH_WAIT_ECHO;
                    timer_next = '0;
                end
            end
            urc_pkg::PH_WAIT_ECHO:
            begin
                if (echo_level)
                begin
                    echo_ticks_next = urc_pkg::COUNT_BITS'(1);
                    phase_next      = urc_pkg::PH_COUNT;
                end
            end
            urc_pkg::PH_COUNT:
            begin
                if (echo_level)
                begin
                    if (echo_ticks_reg < urc_pkg::COUNT_MAX)
                    begin
                        echo_ticks_next = echo_ticks_reg + 1'b1;
                    end
                end
                else
                begin
                    dist_next      = dist_calc;
                    indicator_next = (dist_calc < urc_pkg::DIST_BITS'(cfg.threshold_cm))
                                   ? urc_pkg::IND_NEAR : urc_pkg::IND_FAR;
                    valid          = 1'b1;
                    timer_next     = '0;
                    phase_next     = (cfg.holdoff_ticks == '0) ? urc_pkg::PH_PRE_LOW
                                                               : urc_pkg::PH_HOLDOFF;
                end
            end
            urc_pkg::PH_HOLDOFF:
            begin
                timer_next = timer_inc;
                if (timer_done)
                begin
                    phase_next = urc_pkg::PH_PRE_LOW;
                    timer_next = '0;
                end
            end
            default:
            begin
                phase_next = urc_pkg::PH_PRE_LOW;
                timer_next = timer_inc;
                if (timer_done)
                begin
                    phase_next = urc_pkg::PH_TRIG_HIGH;
                    timer_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= urc_pkg::PH_PRE_LOW;
            timer_reg      <= '0;
            echo_ticks_reg <= '0;
            dist_reg       <= '0;
            indicator_reg  <= urc_pkg::IND_OFF;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            timer_reg      <= timer_next;
            echo_ticks_reg <= echo_ticks_next;
            dist_reg       <= dist_next;
            indicator_reg  <= indicator_next;
        end
    end

    assign result.trigger_level  = trig;
    assign result.distance_valid = valid;
    assign result.distance_cm    = dist_next;
    assign result.led_near       = indicator_next[0];
    assign result.led_far        = indicator_next[1];

    `URC_ASSERT(a_count_nonzero, (phase_reg == urc_pkg::PH_COUNT) |-> (echo_ticks_reg != '0))
    `URC_ASSERT(a_ind_onehot0, $onehot0(indicator_reg))
    `URC_ASSERT(a_idle_holds, !step |=> ($stable(phase_reg) && $stable(timer_reg)))
    `URC_ASSERT(a_meas_exit, (step && valid) |=>
        (phase_reg == urc_pkg::PH_HOLDOFF || phase_reg == urc_pkg::PH_PRE_LOW))

endmodule

/* rtl/urc_out_buf.sv */
// ---------------------------------------------------------------------------
// Ultrasonic range controller output buffer
// Output register plus skid stage; input ready is driven from the skid flag.
// ---------------------------------------------------------------------------
module urc_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  urc_pkg::result_t  in_beat,
    output logic              out_valid,
    input  logic              out_ready,
    output urc_pkg::result_t  out_beat
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    urc_pkg::result_t  out_reg;
    urc_pkg::result_t  skid_reg;
    logic              acc;
    logic              room;

    assign in_ready  = !skid_valid_reg;
    assign acc       = in_valid && in_ready;
    assign room      = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (room)
        begin
            out_valid_reg  <= skid_valid_reg || acc;
            skid_valid_reg <= 1'b0;
        end
        else if (acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room)
        begin
            out_reg <= skid_valid_reg ? skid_reg : in_beat;
        end
        else if (acc)
        begin
            skid_reg <= in_beat;
        end
    end

endmodule

/* rtl/ultrasonic_range_controller.sv */
// A result beat is registered in the output or skid register. One tick beat
// per cycle while in_ready is high; the phase update is a single pass from
// the state registers through the timer compare and distance multiply.
// A two-deep output buffer registers in_ready, with no path from out_ready.
// Reset (rst_n low, async): pre-low phase, counters and distance zero,
// indicators off, registers at their defaults; no clearing pass.
// ---------------------------------------------------------------------------
// Ultrasonic range controller
// Trigger/echo ranging sequencer with distance output and near/far indicator.
// ---------------------------------------------------------------------------
module ultrasonic_range_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [urc_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [urc_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [urc_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               echo_level,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               trigger_level,
    output logic                               distance_valid,
    output logic [urc_pkg::DIST_BITS-1:0]      distance_cm,
    output logic                               led_near,
    output logic                               led_far
);

    urc_pkg::cfg_t     cfg;
    urc_pkg::result_t  core_beat;
    urc_pkg::result_t  out_beat;
    logic              step;

    assign step = in_valid && in_ready;

    urc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    urc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .echo_level (echo_level),
        .cfg        (cfg),
        .result     (core_beat)
    );

    urc_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (core_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    assign trigger_level  = out_beat.trigger_level;
    assign distance_valid = out_beat.distance_valid;
    assign distance_cm    = out_beat.distance_cm;
    assign led_near       = out_beat.led_near;
    assign led_far        = out_beat.led_far;

endmodule

/* bench/ultrasonic_range_controller_tb.sv */
// ---------------------------------------------------------------------------
// Ultrasonic range controller testbench
// Streams echo samples into the ranging sequencer one tick beat at a time and
// checks every result beat against an in-bench model of the trigger, echo
// count, distance and near/far indicator. Register writes go through the
// APB port between phases, with random stalls on both streaming sides.
// ---------------------------------------------------------------------------
module ultrasonic_range_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam logic [urc_pkg::HOLDOFF_BITS-1:0] HOLDOFF_MAX = '1;

    logic                               clk        = 1'b0;
    logic                               rst_n      = 1'b0;
    logic                               psel       = 1'b0;
    logic                               penable    = 1'b0;
    logic                               pwrite     = 1'b0;
    logic [urc_pkg::CFG_ADDR_BITS-1:0]  paddr      = '0;
    logic [urc_pkg::CFG_DATA_BITS-1:0]  pwdata     = '0;
    logic [urc_pkg::CFG_DATA_BITS-1:0]  prdata;
    logic                               pready;
    logic                               in_valid   = 1'b0;
    logic                               in_ready;
    logic                               echo_level = 1'b0;
    logic                               out_valid;
    logic                               out_ready  = 1'b0;
    logic                               trigger_level;
    logic                               distance_valid;
    logic [urc_pkg::DIST_BITS-1:0]      distance_cm;
    logic                               led_near;
    logic                               led_far;

    ultrasonic_range_controller dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .echo_level     (echo_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .trigger_level  (trigger_level),
        .distance_valid (distance_valid),
        .distance_cm    (distance_cm),
        .led_near       (led_near),
        .led_far        (led_far)
    );

    // ranging model state and register shadow
    urc_pkg::phase_t                 rng_phase   = urc_pkg::PH_PRE_LOW;
    logic [urc_pkg::TIMER_BITS-1:0]  rng_timer   = '0;
    logic [urc_pkg::COUNT_BITS-1:0]  rng_ticks   = '0;
    logic [urc_pkg::DIST_BITS-1:0]   rng_last_cm = '0;
    logic [1:0]                      rng_ind     = urc_pkg::IND_OFF;
    urc_pkg::cfg_t                   urc_cfg     = '{
        threshold_cm:  urc_pkg::THRESH_BITS'(10),
        holdoff_ticks: urc_pkg::HOLDOFF_BITS'(10000),
        trigger_ticks: urc_pkg::PULSE_BITS'(1),
        pre_low_ticks: urc_pkg::PULSE_BITS'(1)
    };

    logic             echo_q[$];
    urc_pkg::result_t reading_q[$];
    bit      idle_en        = 1'b1;
    int      ticks_issued   = 0;
    int      readings_seen  = 0;
    int      fail_count     = 0;
    int      in_gap         = 0;
    int      out_gap        = 0;
    int      stall_cycles   = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] pulse_len(input logic [urc_pkg::PULSE_BITS-1:0] v);
        return (v == '0) ? 32'd1 : 32'(v);
    endfunction

    // bump the phase timer; true once the clipped limit is reached
    function automatic logic timer_done(input logic [31:0] limit);
        logic [31:0] lim;
        lim = (limit > 32'(urc_pkg::TIMER_MAX)) ? 32'(urc_pkg::TIMER_MAX) : limit;
        if (rng_timer != urc_pkg::TIMER_MAX)
            rng_timer = rng_timer + 1'b1;
        return 32'(rng_timer) >= lim;
    endfunction

    function automatic urc_pkg::result_t range_step(input logic echo);
        urc_pkg::result_t r;
        logic [31:0]      cm;
        r = '0;
        case (rng_phase)
            urc_pkg::PH_TRIG_HIGH:
            begin
                r.trigger_level = 1'b1;
                if (timer_done(pulse_len(urc_cfg.trigger_ticks)))
                begin
                    rng_phase = urc_pkg::PH_WAIT_ECHO;
                    rng_timer = '0;
                end
            end
            urc_pkg::PH_WAIT_ECHO:
            begin
                if (echo)
                begin
                    rng_ticks = urc_pkg::COUNT_BITS'(1);
                    rng_phase = urc_pkg::PH_COUNT;
                end
            end
            urc_pkg::PH_COUNT:
            begin
                if (echo)
                begin
                    if (rng_ticks != urc_pkg::COUNT_MAX)
                        rng_ticks = rng_ticks + 1'b1;
                end
                else
                begin
                    cm = (32'(rng_ticks) * 32'd17) / 32'd100;
                    rng_last_cm = (cm > 32'(urc_pkg::DIST_MAX)) ? urc_pkg::DIST_MAX
                                                                : cm[urc_pkg::DIST_BITS-1:0];
                    rng_ind = (32'(rng_last_cm) < 32'(urc_cfg.threshold_cm))
                            ? urc_pkg::IND_NEAR : urc_pkg::IND_FAR;
                    r.distance_valid = 1'b1;
                    rng_timer = '0;
                    rng_phase = (urc_cfg.holdoff_ticks == '0) ? urc_pkg::PH_PRE_LOW
                                                              : urc_pkg::PH_HOLDOFF;
                end
            end
            urc_pkg::PH_HOLDOFF:
            begin
                if (timer_done(32'(urc_cfg.holdoff_ticks)))
                begin
                    rng_phase = urc_pkg::PH_PRE_LOW;
                    rng_timer = '0;
                end
            end
            default:
            begin
                rng_phase = urc_pkg::PH_PRE_LOW;
                if (timer_done(pulse_len(urc_cfg.pre_low_ticks)))
                begin
                    rng_phase = urc_pkg::PH_TRIG_HIGH;
                    rng_timer = '0;
                end
            end
        endcase
        r.distance_cm = rng_last_cm;
        r.led_near    = (rng_ind & urc_pkg::IND_NEAR) != urc_pkg::IND_OFF;
        r.led_far     = (rng_ind & urc_pkg::IND_FAR) != urc_pkg::IND_OFF;
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] word;
        case (idx)
            urc_pkg::REG_THRESHOLD: mask = (32'd1 << urc_pkg::THRESH_BITS) - 1;
            urc_pkg::REG_HOLDOFF:   mask = (32'd1 << urc_pkg::HOLDOFF_BITS) - 1;
            default:                mask = (32'd1 << urc_pkg::PULSE_BITS) - 1;
        endcase
        // junk above the register width must be dropped
        word = ($urandom & ~mask) | (val & mask);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= urc_pkg::CFG_ADDR_BITS'({idx, 2'b00});
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            urc_pkg::REG_THRESHOLD:
                urc_cfg.threshold_cm  = word[urc_pkg::THRESH_BITS-1:0];
            urc_pkg::REG_HOLDOFF:
                urc_cfg.holdoff_ticks = word[urc_pkg::HOLDOFF_BITS-1:0];
            urc_pkg::REG_TRIGGER:
                urc_cfg.trigger_ticks = word[urc_pkg::PULSE_BITS-1:0];
            default:
                urc_cfg.pre_low_ticks = word[urc_pkg::PULSE_BITS-1:0];
        endcase
    endtask

    task automatic push_level(input logic lvl, input int n);
        repeat (n)
            echo_q.push_back(lvl);
        ticks_issued += n;
    endtask

    task automatic wait_drained();
        while (readings_seen < ticks_issued)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic int lead_len();
        return int'(urc_cfg.holdoff_ticks) + int'(pulse_len(urc_cfg.pre_low_ticks))
             + int'(pulse_len(urc_cfg.trigger_ticks));
    endfunction

    function automatic int echo_len();
        return ($urandom_range(0, 4) != 0) ? $urandom_range(1, 60) : $urandom_range(1, 1200);
    endfunction

    task automatic random_config(input bit extremes);
        int sel;
        if (extremes)
        begin
            write_reg(urc_pkg::REG_THRESHOLD, 1023);
            write_reg(urc_pkg::REG_HOLDOFF, 0);
            write_reg(urc_pkg::REG_TRIGGER, 255);
            write_reg(urc_pkg::REG_PRE_LOW, 255);
        end
        else
        begin
            sel = $urandom_range(0, 9);
            write_reg(urc_pkg::REG_THRESHOLD,
                      (sel == 0) ? 0 : (sel == 1) ? 1023 : $urandom_range(0, 220));
            sel = $urandom_range(0, 19);
            write_reg(urc_pkg::REG_HOLDOFF,
                      (sel < 4) ? 0 : (sel == 4) ? $urandom_range(100, 2000)
                                                 : $urandom_range(1, 30));
            sel = $urandom_range(0, 9);
            write_reg(urc_pkg::REG_TRIGGER,
                      (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(1, 6));
            sel = $urandom_range(0, 9);
            write_reg(urc_pkg::REG_PRE_LOW,
                      (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(1, 6));
        end
    endtask

    // mostly clean trigger/echo cycles, some noise and early echoes
    task automatic run_random_phase(input int n_items, input bit idle_on);
        int start;
        int kind;
        start   = ticks_issued;
        idle_en = idle_on;
        while (ticks_issued - start < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                push_level(1'b0, lead_len() + $urandom_range(0, 4));
                push_level(1'b1, echo_len());
            end
            else if (kind < 90)
            begin
                repeat ($urandom_range(1, 20))
                    push_level(1'($urandom_range(0, 1)), 1);
            end
            else
            begin
                push_level(1'b0, $urandom_range(0, lead_len()));
                push_level(1'b1, echo_len());
            end
        end
        push_level(1'b0, 1);
    endtask

    // tick driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (echo_q.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= $urandom_range(0, 10);
            end
            else
            begin
                in_valid   <= 1'b1;
                echo_level <= echo_q.pop_front();
            end
        end
    end

    // result side backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (out_gap > 0)
        begin
            out_ready <= 1'b0;
            out_gap   <= out_gap - 1;
        end
        else if (idle_en && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 1'b0;
            out_gap   <= $urandom_range(0, 10);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // monitor: check result beats, then predict from accepted tick beats
    always @(posedge clk)
    begin
        urc_pkg::result_t got;
        urc_pkg::result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                readings_seen <= readings_seen + 1;
                got = {trigger_level, distance_valid, distance_cm, led_near, led_far};
                if (reading_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected beat: trig=%0b valid=%0b cm=%0d near=%0b far=%0b",
                                 got.trigger_level, got.distance_valid, got.distance_cm,
                                 got.led_near, got.led_far);
                end
                else
                begin
                    want = reading_q.pop_front();
                    if (got.trigger_level !== want.trigger_level
                        || got.distance_valid !== want.distance_valid
                        || got.distance_cm !== want.distance_cm
                        || got.led_near !== want.led_near
                        || got.led_far !== want.led_far)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("mismatch @%0t exp: trig=%0b valid=%0b cm=%0d near=%0b far=%0b",
                                     $realtime, want.trigger_level, want.distance_valid,
                                     want.distance_cm, want.led_near, want.led_far);
                            $display("             got: trig=%0b valid=%0b cm=%0d near=%0b far=%0b",
                                     got.trigger_level, got.distance_valid, got.distance_cm,
                                     got.led_near, got.led_far);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                reading_q.push_back(range_step(echo_level));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: echo on the first wait tick counts as one tick
        push_level(1'b1, 3);
        push_level(1'b0, 1);
        push_level(1'b1, 3);
        wait_drained();

        // holdoff cut below elapsed time, zero pulse lengths, threshold edge
        write_reg(urc_pkg::REG_HOLDOFF, 1);
        write_reg(urc_pkg::REG_THRESHOLD, 1);
        write_reg(urc_pkg::REG_TRIGGER, 0);
        write_reg(urc_pkg::REG_PRE_LOW, 0);
        push_level(1'b0, 4);
        push_level(1'b1, 6);
        push_level(1'b0, 4);
        push_level(1'b1, 5);
        push_level(1'b0, 1);
        wait_drained();

        // zero holdoff goes straight back to pre low
        write_reg(urc_pkg::REG_HOLDOFF, 0);
        write_reg(urc_pkg::REG_THRESHOLD, 0);
        push_level(1'b0, 2);
        push_level(1'b1, 1);
        push_level(1'b0, 1);
        push_level(1'b1, 3);
        push_level(1'b0, 1);
        wait_drained();

        // full-scale holdoff, then lowered while running
        write_reg(urc_pkg::REG_HOLDOFF, 32'(HOLDOFF_MAX));
        push_level(1'b0, 2);
        push_level(1'b1, 1);
        push_level(1'b0, 8);
        wait_drained();
        write_reg(urc_pkg::REG_HOLDOFF, 5);
        push_level(1'b0, 3);
        push_level(1'b1, 3);
        push_level(1'b0, 1);

        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            random_config(p == 0);
            run_random_phase(100, p != 3);
        end

        wait_drained();
        idle_en = 1'b0;
        random_config(1'b0);
        run_random_phase(150, 1'b0);
        wait_drained();
        repeat (4) @(posedge clk);

        if (fail_count == 0 && reading_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
